FILE: hdl/pwfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwfd_pkg;

	// Sequencer states, one-hot
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_M1   = 8'b0000_0010,
		S_M2   = 8'b0000_0100,
		S_M3   = 8'b0000_1000,
		S_M4   = 8'b0001_0000,
		S_M5   = 8'b0010_0000,
		S_M6   = 8'b0100_0000,
		S_SUM  = 8'b1000_0000
	} state_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 4;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PROP_GAIN       = 4'd0;
	localparam cfg_idx_t REG_INTEG_GAIN      = 4'd1;
	localparam cfg_idx_t REG_SETPOINT_WEIGHT = 4'd2;
	localparam cfg_idx_t REG_DERIV_POLE      = 4'd3;
	localparam cfg_idx_t REG_DERIV_SCALE     = 4'd4;
	localparam cfg_idx_t REG_REVERSE_DIR     = 4'd5;
	localparam cfg_idx_t REG_INTEG_LIMIT     = 4'd6;
	localparam cfg_idx_t REG_OUT_LIMIT       = 4'd7;

	// Reset values
	localparam logic [30:0] PROP_GAIN_RST       = 31'd65536;
	localparam logic [30:0] SETPOINT_WEIGHT_RST = 31'd65536;

endpackage

`default_nettype wire

FILE: hdl/pid_weighted_filtered_derivative_top.sv
// After acceptance the sequencer steps through M1 to M6 and SUM and loads the drive
// result into the output register in SUM, where it waits while out_stall holds a finished
// result; no new item is taken before then. One shared 32x32 multiplier forms the five
// products of an item in turn. in_stall is high from acceptance until the result is loaded
// into the output register. Reset (arst_n low) clears the integral, the derivative filter,
// the previous measurement, the state and out_valid, and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module pid_weighted_filtered_derivative_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire pwfd_pkg::cfg_idx_t cfg_index,
	input  wire logic [31:0]        cfg_data,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] reference,
	input  wire logic signed [31:0] measured,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      drive
);

	// Saturate a 48-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (!v[47] && (|v[46:31]))
			r = 32'sh7FFF_FFFF;
		else if (v[47] && !(&v[46:31]))
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Saturating negate
	function automatic logic signed [31:0] negsat(input logic signed [31:0] x);
		logic signed [47:0] n;
		n = -48'(x);
		return sat32(n);
	endfunction

	// Symmetric clamp to +/- lim
	function automatic logic signed [31:0] clampsym(input logic signed [31:0] v,
			input logic [30:0] lim);
		logic signed [32:0] vp;
		logic signed [32:0] lp;
		logic signed [31:0] r;
		vp = 33'(v);
		lp = $signed({2'b00, lim});
		if (vp > lp)
			r = lp[31:0];
		else if (vp < -lp)
			r = 32'(-lp);
		else
			r = v;
		return r;
	endfunction

	// Configuration registers
	logic [30:0]        prop_gain_q;
	logic [30:0]        integ_gain_q;
	logic [30:0]        setpoint_weight_q;
	logic [16:0]        deriv_pole_q;
	logic signed [31:0] deriv_scale_q;
	logic               reverse_dir_q;
	logic [30:0]        integ_limit_q;
	logic [30:0]        out_limit_q;

	// Controller state
	pwfd_pkg::state_t   state_q;
	logic signed [31:0] integ_acc_q;
	logic signed [31:0] deriv_acc_q;
	logic signed [31:0] prev_meas_q;

	// Per-item working registers
	logic signed [31:0] ref_q;
	logic signed [31:0] meas_q;
	logic signed [31:0] err_q;
	logic signed [31:0] dmeas_q;
	logic signed [31:0] perr_q;
	logic signed [31:0] pterm_q;
	logic signed [31:0] dpole_q;
	logic signed [63:0] prod_q;

	// Output register
	logic               out_valid_q;
	logic signed [31:0] drive_q;

	// Shared multiplier operands
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [31:0] mq;
	logic signed [31:0] err_c;
	logic signed [31:0] dmeas_c;
	logic signed [31:0] perr_c;
	logic signed [31:0] integ_c;
	logic signed [31:0] u_c;
	logic               in_acc;
	logic               out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != pwfd_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q       <= pwfd_pkg::PROP_GAIN_RST;
			integ_gain_q      <= '0;
			setpoint_weight_q <= pwfd_pkg::SETPOINT_WEIGHT_RST;
			deriv_pole_q      <= '0;
			deriv_scale_q     <= '0;
			reverse_dir_q     <= 1'b0;
			integ_limit_q     <= '0;
			out_limit_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pwfd_pkg::REG_PROP_GAIN:       prop_gain_q       <= cfg_data[30:0];
				pwfd_pkg::REG_INTEG_GAIN:      integ_gain_q      <= cfg_data[30:0];
				pwfd_pkg::REG_SETPOINT_WEIGHT: setpoint_weight_q <= cfg_data[30:0];
				pwfd_pkg::REG_DERIV_POLE:      deriv_pole_q      <= cfg_data[16:0];
				pwfd_pkg::REG_DERIV_SCALE:     deriv_scale_q     <= $signed(cfg_data);
				pwfd_pkg::REG_REVERSE_DIR:     reverse_dir_q     <= cfg_data[0];
				pwfd_pkg::REG_INTEG_LIMIT:     integ_limit_q     <= cfg_data[30:0];
				pwfd_pkg::REG_OUT_LIMIT:       out_limit_q       <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Error and measurement change at acceptance
	always_comb begin
		err_c   = sat32(48'(reference) - 48'(measured));
		dmeas_c = sat32(48'(measured) - 48'(prev_meas_q));
		if (reverse_dir_q)
			err_c = negsat(err_c);
	end

	// Product of the previous cycle, floor-shifted and saturated
	assign mq = sat32(prod_q[63:16]);

	// Terms formed from the registered product
	always_comb begin
		perr_c = sat32(48'(mq) - 48'(meas_q));
		if (reverse_dir_q)
			perr_c = negsat(perr_c);
		integ_c = clampsym(sat32(48'(integ_acc_q) + 48'(mq)), integ_limit_q);
		u_c     = clampsym(sat32(48'(pterm_q) + 48'(integ_acc_q) + 48'(deriv_acc_q)),
			out_limit_q);
	end

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			pwfd_pkg::S_M1: begin
				mul_a = $signed({1'b0, setpoint_weight_q});
				mul_b = ref_q;
			end
			pwfd_pkg::S_M2: begin
				mul_a = $signed({1'b0, integ_gain_q});
				mul_b = err_q;
			end
			pwfd_pkg::S_M3: begin
				mul_a = $signed({1'b0, prop_gain_q});
				mul_b = perr_q;
			end
			pwfd_pkg::S_M4: begin
				mul_a = deriv_acc_q;
				mul_b = $signed({15'd0, deriv_pole_q});
			end
			pwfd_pkg::S_M5: begin
				mul_a = deriv_scale_q;
				mul_b = dmeas_q;
			end
			default: ;
		endcase
	end

	// Shared multiplier output register
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sequencer and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pwfd_pkg::S_IDLE;
			integ_acc_q <= '0;
			deriv_acc_q <= '0;
			prev_meas_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Output register: load a finished result or drop a taken one
			if (state_q == pwfd_pkg::S_SUM && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				pwfd_pkg::S_IDLE: begin
					if (in_acc) begin
						prev_meas_q <= measured;
						state_q     <= pwfd_pkg::S_M1;
					end
				end
				pwfd_pkg::S_M1: state_q <= pwfd_pkg::S_M2;
				pwfd_pkg::S_M2: state_q <= pwfd_pkg::S_M3;
				pwfd_pkg::S_M3: begin
					integ_acc_q <= integ_c;
					state_q     <= pwfd_pkg::S_M4;
				end
				pwfd_pkg::S_M4: state_q <= pwfd_pkg::S_M5;
				pwfd_pkg::S_M5: state_q <= pwfd_pkg::S_M6;
				pwfd_pkg::S_M6: begin
					deriv_acc_q <= sat32(48'(dpole_q) + 48'(mq));
					state_q     <= pwfd_pkg::S_SUM;
				end
				pwfd_pkg::S_SUM: begin
					if (out_free)
						state_q <= pwfd_pkg::S_IDLE;
				end
				default: state_q <= pwfd_pkg::S_IDLE;
			endcase
		end
	end

	// Working data registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ref_q   <= reference;
			meas_q  <= measured;
			err_q   <= err_c;
			dmeas_q <= dmeas_c;
		end
		if (state_q == pwfd_pkg::S_M2)
			perr_q <= perr_c;
		if (state_q == pwfd_pkg::S_M4)
			pterm_q <= mq;
		if (state_q == pwfd_pkg::S_M5)
			dpole_q <= mq;
		if (state_q == pwfd_pkg::S_SUM && out_free)
			drive_q <= u_c;
	end

	// Checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == pwfd_pkg::S_M1)
		else $error("accepted transaction did not start the sequence");

	a_sum_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pwfd_pkg::S_SUM && out_valid_q && out_stall
		|=> state_q == pwfd_pkg::S_SUM && out_valid_q)
		else $error("result overwritten while output stalled");

	a_drive_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (33'(drive_q) <= $signed({2'b00, out_limit_q}))
			&& (33'(drive_q) >= -$signed({2'b00, out_limit_q})))
		else $error("drive outside output limit");

endmodule

`default_nettype wire

FILE: tb/tb_pid_weighted_filtered_derivative_top.sv
`timescale 1ns / 1ps

module tb_pid_weighted_filtered_derivative_top;

	localparam int     DRAIN_CYCLES = 16;
	localparam int     HOLD_CYCLES  = 300;
	localparam longint TIMEOUT_NS   = 4_000_000;
	localparam longint WORD_MAX     = 64'sd2147483647;
	localparam longint WORD_MIN     = -WORD_MAX - 1;

	localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
	localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
	localparam logic [30:0]        U_MAX  = 31'h7FFF_FFFF;
	localparam logic [30:0]        U_ONE  = 31'h0001_0000;
	localparam logic [16:0]        P_FULL = 17'h1_FFFF;
	localparam logic [16:0]        P_ONE  = 17'h1_0000;

	// One full set of controller registers
	typedef struct {
		logic [30:0]        prop_gain;
		logic [30:0]        integ_gain;
		logic [30:0]        setpoint_weight;
		logic [16:0]        deriv_pole;
		logic signed [31:0] deriv_scale;
		logic               reverse_dir;
		logic [30:0]        integ_limit;
		logic [30:0]        out_limit;
	} pid_setting_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	pwfd_pkg::cfg_idx_t cfg_index = '0;
	logic [31:0]        cfg_data  = '0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic signed [31:0] reference = '0;
	logic signed [31:0] measured  = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] drive;

	// Controller model: registers and loop state
	pid_setting_t       cfg_model;
	logic signed [31:0] integ_st     = '0;
	logic signed [31:0] deriv_st     = '0;
	logic signed [31:0] prev_meas_st = '0;

	logic signed [31:0] exp_drive_q[$];
	int                 n_sent     = 0;
	int                 n_checked  = 0;
	int                 n_settings = 0;
	int                 n_fail     = 0;
	bit                 idle_on    = 1'b1;
	logic               hold_active = 1'b0;
	event               hold_go;

	pid_weighted_filtered_derivative_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.reference (reference),
		.measured  (measured),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Fixed-point helpers
	function automatic longint sat_word(input longint v);
		if (v > WORD_MAX) return WORD_MAX;
		if (v < WORD_MIN) return WORD_MIN;
		return v;
	endfunction

	// Q16.16 product, floor shift, saturated
	function automatic longint qmul(input longint a, input longint b);
		longint p;
		p = a * b;
		return sat_word(p >>> 16);
	endfunction

	function automatic longint clamp_sym(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Advance the loop state by one sample and return the expected drive
	function automatic logic signed [31:0] predict_drive(input logic signed [31:0] ref_v,
			input logic signed [31:0] meas_v);
		longint r, y, err, perr, p, d, acc, u;
		r    = longint'(ref_v);
		y    = longint'(meas_v);
		err  = sat_word(r - y);
		perr = sat_word(qmul(longint'(cfg_model.setpoint_weight), r) - y);
		if (cfg_model.reverse_dir) begin
			err  = sat_word(-err);
			perr = sat_word(-perr);
		end
		p = qmul(longint'(cfg_model.prop_gain), perr);

		acc = sat_word(longint'(integ_st) + qmul(longint'(cfg_model.integ_gain), err));
		acc = clamp_sym(acc, longint'(cfg_model.integ_limit));
		integ_st = acc[31:0];

		d   = sat_word(y - longint'(prev_meas_st));
		acc = sat_word(qmul(longint'(deriv_st), longint'(cfg_model.deriv_pole)) +
			qmul(longint'(cfg_model.deriv_scale), d));
		deriv_st     = acc[31:0];
		prev_meas_st = meas_v;

		u = sat_word(p + longint'(integ_st) + longint'(deriv_st));
		u = clamp_sym(u, longint'(cfg_model.out_limit));
		return u[31:0];
	endfunction

	function automatic pid_setting_t default_setting();
		pid_setting_t s;
		s.prop_gain       = pwfd_pkg::PROP_GAIN_RST;
		s.integ_gain      = '0;
		s.setpoint_weight = pwfd_pkg::SETPOINT_WEIGHT_RST;
		s.deriv_pole      = '0;
		s.deriv_scale     = '0;
		s.reverse_dir     = 1'b0;
		s.integ_limit     = '0;
		s.out_limit       = '0;
		return s;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Sample values: mostly moderate so the loop state evolves, some full range
	function automatic logic signed [31:0] rand_sample();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					default: return -1;
				endcase
			end
			1, 2: return $urandom;
			default: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		endcase
	endfunction

	function automatic logic [30:0] rand_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return U_MAX;
			2: return 31'($urandom);
			default: return 31'($urandom_range(0, 4 * 65536));
		endcase
	endfunction

	function automatic logic [30:0] rand_limit();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return U_MAX;
			2: return 31'($urandom);
			default: return 31'($urandom_range(65536, 64 * 65536));
		endcase
	endfunction

	function automatic pid_setting_t rand_setting();
		pid_setting_t s;
		s.prop_gain       = rand_gain();
		s.integ_gain      = rand_gain() >> $urandom_range(0, 4);
		s.setpoint_weight = ($urandom_range(0, 3) == 0) ? rand_gain() :
			31'($urandom_range(0, 2 * 65536));
		case ($urandom_range(0, 7))
			0: s.deriv_pole = P_FULL;
			1: s.deriv_pole = 17'($urandom_range(65537, 131071));
			2: s.deriv_pole = P_ONE;
			default: s.deriv_pole = 17'($urandom_range(0, 65536));
		endcase
		case ($urandom_range(0, 7))
			0: s.deriv_scale = Q_MIN;
			1: s.deriv_scale = Q_MAX;
			2: s.deriv_scale = $urandom;
			default: s.deriv_scale = int'($urandom_range(0, 1 << 19)) - (1 << 18);
		endcase
		s.reverse_dir = 1'($urandom);
		s.integ_limit = rand_limit();
		s.out_limit   = rand_limit();
		return s;
	endfunction

	// Config write; leaves cfg_valid high, the caller lowers it after the batch
	task automatic write_reg(input pwfd_pkg::cfg_idx_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pwfd_pkg::REG_PROP_GAIN:       cfg_model.prop_gain       = data[30:0];
			pwfd_pkg::REG_INTEG_GAIN:      cfg_model.integ_gain      = data[30:0];
			pwfd_pkg::REG_SETPOINT_WEIGHT: cfg_model.setpoint_weight = data[30:0];
			pwfd_pkg::REG_DERIV_POLE:      cfg_model.deriv_pole      = data[16:0];
			pwfd_pkg::REG_DERIV_SCALE:     cfg_model.deriv_scale     = data;
			pwfd_pkg::REG_REVERSE_DIR:     cfg_model.reverse_dir     = data[0];
			pwfd_pkg::REG_INTEG_LIMIT:     cfg_model.integ_limit     = data[30:0];
			pwfd_pkg::REG_OUT_LIMIT:       cfg_model.out_limit       = data[30:0];
			default: ;
		endcase
	endtask

	// Write all eight registers; unused upper bits carry random junk
	task automatic apply_setting(input pid_setting_t s);
		write_reg(pwfd_pkg::REG_PROP_GAIN,       {1'($urandom), s.prop_gain});
		write_reg(pwfd_pkg::REG_INTEG_GAIN,      {1'($urandom), s.integ_gain});
		write_reg(pwfd_pkg::REG_SETPOINT_WEIGHT, {1'($urandom), s.setpoint_weight});
		write_reg(pwfd_pkg::REG_DERIV_POLE,      {15'($urandom), s.deriv_pole});
		write_reg(pwfd_pkg::REG_DERIV_SCALE,     s.deriv_scale);
		write_reg(pwfd_pkg::REG_REVERSE_DIR,     {31'($urandom), s.reverse_dir});
		write_reg(pwfd_pkg::REG_INTEG_LIMIT,     {1'($urandom), s.integ_limit});
		write_reg(pwfd_pkg::REG_OUT_LIMIT,       {1'($urandom), s.out_limit});
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Offer one sample; valid stays high when the next one follows at once
	task automatic send_sample(input logic signed [31:0] ref_v,
			input logic signed [31:0] meas_v);
		int gap;
		in_valid  <= 1'b1;
		reference <= ref_v;
		measured  <= meas_v;
		do @(posedge clk); while (in_stall);
		exp_drive_q.push_back(predict_drive(ref_v, meas_v));
		n_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and let every outstanding result come back
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (exp_drive_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reset values: zero output limit forces drive to zero
	task automatic test_reset_defaults();
		send_sample(Q_ONE, '0);
		send_sample(Q_MAX, Q_MIN);
		send_sample(Q_MIN, Q_MAX);
		send_sample(-Q_ONE, 32'sh0003_8000);
	endtask

	// Unity gains, wide limits, extreme operands
	task automatic test_extremes();
		pid_setting_t s;
		wait_drain();
		s = default_setting();
		s.integ_gain  = U_ONE;
		s.deriv_scale = Q_ONE;
		s.integ_limit = U_MAX;
		s.out_limit   = U_MAX;
		apply_setting(s);
		send_sample(Q_MAX, Q_MIN);
		send_sample(Q_MIN, Q_MAX);
		send_sample('0, '0);
		send_sample(-1, 1);
		send_sample(Q_MAX, Q_MAX);
	endtask

	// Reverse acting, including negation of the most negative error
	task automatic test_reverse();
		pid_setting_t s;
		wait_drain();
		s = cfg_model;
		s.reverse_dir = 1'b1;
		s.prop_gain   = U_MAX;
		apply_setting(s);
		send_sample(Q_MIN, '0);
		send_sample('0, Q_MAX);
		send_sample(Q_ONE, -Q_ONE);
	endtask

	// Filter pole above one lets the derivative grow until it saturates
	task automatic test_pole_above_one();
		pid_setting_t s;
		wait_drain();
		s = default_setting();
		s.deriv_pole  = P_FULL;
		s.deriv_scale = Q_MAX;
		s.out_limit   = U_MAX;
		apply_setting(s);
		send_sample('0, Q_ONE);
		send_sample('0, -Q_ONE);
		send_sample('0, Q_ONE);
		send_sample('0, Q_MIN);
		send_sample('0, Q_MAX);
	endtask

	// Zero integral limit with open output limit
	task automatic test_limits();
		pid_setting_t s;
		wait_drain();
		s = default_setting();
		s.integ_gain = U_MAX;
		s.out_limit  = U_MAX;
		apply_setting(s);
		send_sample(Q_MAX, '0);
		send_sample(32'sh0002_0000, Q_ONE);
	endtask

	// Writes to unused indexes must leave the registers alone
	task automatic test_unused_index();
		wait_drain();
		for (int k = int'(pwfd_pkg::REG_OUT_LIMIT) + 1; k < (1 << pwfd_pkg::CFG_IDX_W); k++)
			write_reg(pwfd_pkg::cfg_idx_t'(k), $urandom);
		cfg_valid <= 1'b0;
		send_sample(Q_ONE, 32'sh0000_8000);
		send_sample(-Q_ONE, Q_ONE);
		send_sample(rand_sample(), rand_sample());
	endtask

	// Long receiver hold while samples keep coming, then a full pause
	task automatic test_backpressure();
		pid_setting_t s;
		wait_drain();
		s = rand_setting();
		s.out_limit = U_MAX;
		apply_setting(s);
		idle_on = 1'b0;
		-> hold_go;
		for (int i = 0; i < 12; i++)
			send_sample(rand_sample(), rand_sample());
		idle_on = 1'b1;
		wait_drain();
		for (int i = 0; i < 8; i++)
			send_sample(rand_sample(), rand_sample());
	endtask

	// Many register settings, each with a run of random samples
	task automatic test_random_settings(input int n_phases, input int per_phase);
		pid_setting_t s;
		for (int ph = 0; ph < n_phases; ph++) begin
			wait_drain();
			if (ph == 0) begin
				s.prop_gain       = U_MAX;
				s.integ_gain      = U_MAX;
				s.setpoint_weight = U_MAX;
				s.deriv_pole      = P_FULL;
				s.deriv_scale     = Q_MAX;
				s.reverse_dir     = 1'b1;
				s.integ_limit     = U_MAX;
				s.out_limit       = U_MAX;
			end else if (ph == 1) begin
				s.prop_gain       = '0;
				s.integ_gain      = '0;
				s.setpoint_weight = '0;
				s.deriv_pole      = '0;
				s.deriv_scale     = Q_MIN;
				s.reverse_dir     = 1'b0;
				s.integ_limit     = '0;
				s.out_limit       = U_MAX;
			end else begin
				s = rand_setting();
			end
			apply_setting(s);
			idle_on = (ph % 4 != 3);
			for (int i = 0; i < per_phase; i++)
				send_sample(rand_sample(), rand_sample());
		end
		idle_on = 1'b1;
	endtask

	// Receiver pacing: random stalls, stall-free stretches, long hold on request
	int stall_left = 0;
	int free_left  = 0;
	always @(posedge clk) begin
		int r;
		if (free_left > 0) begin
			free_left--;
		end else if (stall_left > 0) begin
			stall_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3)
				free_left = $urandom_range(50, 200);
			else if (r >= 60 && r < 95)
				stall_left = $urandom_range(1, 3);
			else if (r >= 95)
				stall_left = $urandom_range(4, 40);
		end
		out_stall <= hold_active || (stall_left > 0);
	end

	// Long hold, counted here in cycles
	initial begin
		forever begin
			@(hold_go);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	// Compare each drive transaction with the oldest expectation
	always @(posedge clk) begin
		logic signed [31:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (exp_drive_q.size() == 0) begin
				$error("drive: unexpected transaction, expected none, actual %0d", drive);
				n_fail++;
			end else begin
				want = exp_drive_q.pop_front();
				n_checked++;
				if (drive !== want) begin
					$error("drive: expected %0d, actual %0d", want, drive);
					n_fail++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb_pid_weighted_filtered_derivative_top NOT OK");
		$finish;
	end

	initial begin
		cfg_model = default_setting();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_extremes();
		test_reverse();
		test_pole_above_one();
		test_limits();
		test_unused_index();
		test_backpressure();
		test_random_settings(12, 158);
		wait_drain();

		$display("Sent %0d samples, checked %0d drive results over %0d register settings.",
			n_sent, n_checked, n_settings);
		$display("Included saturating operands, reverse acting, pole above one, zero limits,");
		$display("unused register writes and a long output hold.");
		if (n_fail == 0)
			$display("tb_pid_weighted_filtered_derivative_top OK");
		else
			$display("tb_pid_weighted_filtered_derivative_top NOT OK");
		$finish;
	end

endmodule
